>>> design/ocs_pkg.sv
package ocs_pkg;

  // Field and datapath widths
  localparam int CMD_W   = 3;
  localparam int VAL_W   = 24;
  localparam int ANG_W   = 16;
  localparam int EL_W    = 14;
  localparam int TRIG_W  = 34;
  localparam int PROD_W  = 59;
  localparam int MA_W    = 25;
  localparam int SQ_W    = 48;
  localparam int ROOT_W  = 24;
  localparam int SREM_W  = 27;
  localparam int NUM_W   = 40;
  localparam int Q_W     = 17;
  localparam int CNT_W   = 6;
  localparam int ITER_IW = 5;
  localparam int SEL_W   = 3;
  localparam int COMP_W  = 2;

  localparam int AS_W    = 13;
  localparam int DS_W    = 16;
  localparam int MINR_W  = 23;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 23;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 128;

  localparam int TRIG_ITERATIONS_DEF = 16;

  // Loop lengths of the shared units
  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 40;

  // Angle constants, Q4.12
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
  localparam logic signed [16:0] EL_MIN_Q12 = 17'sd41;
  localparam logic signed [16:0] EL_MAX_Q12 = 17'sd12827;

  // Angle constants, Q28, and CORDIC start value, Q30
  localparam logic signed [TRIG_W-1:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [TRIG_W-1:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [TRIG_W-1:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Reset values
  localparam logic [AS_W-1:0]          ANGLE_STEP_RST = 13'd819;
  localparam logic [DS_W-1:0]          DIST_STEP_RST  = 16'd819;
  localparam logic [MINR_W-1:0]        MIN_RADIUS_RST = 23'd4096;
  localparam logic [EL_W-1:0]          EL_RST         = 14'd6434;
  localparam logic signed [ANG_W-1:0]  AZ_RST         = -16'sd6434;
  localparam logic signed [VAL_W-1:0]  RADIUS_RST     = 24'sd40960;
  localparam logic signed [VAL_W-1:0]  OFFZ_RST       = 24'sd40960;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_ANGLE_STEP = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DIST_STEP  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_MIN_RADIUS = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_FWD     = 3'd0,
    CMD_BACK    = 3'd1,
    CMD_LEFT    = 3'd2,
    CMD_RIGHT   = 3'd3,
    CMD_UP      = 3'd4,
    CMD_DOWN    = 3'd5,
    CMD_SET_RAD = 3'd6,
    CMD_SET_OFF = 3'd7
  } command_t;

  // Multiplier operand selects
  localparam logic [SEL_W-1:0] MSEL_RS   = 3'd0;
  localparam logic [SEL_W-1:0] MSEL_X    = 3'd1;
  localparam logic [SEL_W-1:0] MSEL_Y    = 3'd2;
  localparam logic [SEL_W-1:0] MSEL_Z    = 3'd3;
  localparam logic [SEL_W-1:0] MSEL_SQX  = 3'd4;
  localparam logic [SEL_W-1:0] MSEL_SQY  = 3'd5;
  localparam logic [SEL_W-1:0] MSEL_SQZ  = 3'd6;
  localparam logic [SEL_W-1:0] MSEL_NUM  = 3'd7;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_TRIG_INIT,
    OP_TRIG_STEP,
    OP_TRIG_SAVE,
    OP_MUL,
    OP_MUL_WB,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_STEP,
    OP_DIV_WB,
    OP_RADIUS,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SEL_W-1:0]  sel;
    logic [COMP_W-1:0] comp;
    logic [CNT_W-1:0]  cnt;
  } ctl_t;

  typedef struct packed {
    logic le_min;
    logic len_zero;
  } stat_t;

  // Arctangent table, Q28
  function automatic logic signed [TRIG_W-1:0] atan_q28(input logic [ITER_IW-1:0] i);
    logic signed [TRIG_W-1:0] v;
    case (i)
      5'd0:  v = 34'sd210828714;
      5'd1:  v = 34'sd124459457;
      5'd2:  v = 34'sd65760959;
      5'd3:  v = 34'sd33381290;
      5'd4:  v = 34'sd16755422;
      5'd5:  v = 34'sd8385879;
      5'd6:  v = 34'sd4193963;
      5'd7:  v = 34'sd2097109;
      5'd8:  v = 34'sd1048571;
      5'd9:  v = 34'sd524287;
      5'd10: v = 34'sd262144;
      5'd11: v = 34'sd131072;
      5'd12: v = 34'sd65536;
      5'd13: v = 34'sd32768;
      5'd14: v = 34'sd16384;
      5'd15: v = 34'sd8192;
      5'd16: v = 34'sd4096;
      5'd17: v = 34'sd2048;
      5'd18: v = 34'sd1024;
      5'd19: v = 34'sd512;
      5'd20: v = 34'sd256;
      5'd21: v = 34'sd128;
      5'd22: v = 34'sd64;
      5'd23: v = 34'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate to signed 24 bits
  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [31:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 32'sd8388607)       r = 24'sh7FFFFF;
    else if (v < -32'sd8388608) r = 24'sh800000;
    else                        r = v[VAL_W-1:0];
    return r;
  endfunction

endpackage

>>> design/ocs_ctrl.sv
module ocs_ctrl
  import ocs_pkg::*;
#(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [CMD_W-1:0] in_command,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  stat_t            stat,
  output ctl_t             ctl
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_TINIT = 13'b0000000000010,
    S_TSTEP = 13'b0000000000100,
    S_TSAVE = 13'b0000000001000,
    S_MUL   = 13'b0000000010000,
    S_MWB   = 13'b0000000100000,
    S_SQI   = 13'b0000001000000,
    S_SQS   = 13'b0000010000000,
    S_CHK   = 13'b0000100000000,
    S_DSTEP = 13'b0001000000000,
    S_DWB   = 13'b0010000000000,
    S_RAD   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  localparam logic [CNT_W-1:0] TRIG_LAST = CNT_W'(TRIG_ITERATIONS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
  localparam logic [COMP_W-1:0] COMP_LAST = 2'd2;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic [COMP_W-1:0] comp_r, comp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_fire, out_fire;
  command_t          cmd;

  assign cmd        = command_t'(in_command);
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    comp_nxt      = comp_r;
    out_valid_nxt = out_valid_r;
    ctl.op        = OP_IDLE;
    ctl.sel       = sel_r;
    ctl.comp      = comp_r;
    ctl.cnt       = cnt_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ctl.op   = OP_LOAD;
          comp_nxt = '0;
          cnt_nxt  = '0;
          case (cmd)
            CMD_LEFT, CMD_RIGHT, CMD_UP, CMD_DOWN: state_nxt = S_TINIT;
            CMD_SET_RAD, CMD_SET_OFF:              state_nxt = S_OUT;
            CMD_FWD: begin
              if (stat.le_min) begin
                state_nxt = S_RAD;
              end else begin
                sel_nxt   = MSEL_SQX;
                state_nxt = S_MUL;
              end
            end
            default: begin
              sel_nxt   = MSEL_SQX;
              state_nxt = S_MUL;
            end
          endcase
        end
      end
      S_TINIT: begin
        ctl.op    = OP_TRIG_INIT;
        cnt_nxt   = '0;
        state_nxt = S_TSTEP;
      end
      S_TSTEP: begin
        ctl.op  = OP_TRIG_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == TRIG_LAST) state_nxt = S_TSAVE;
      end
      S_TSAVE: begin
        ctl.op = OP_TRIG_SAVE;
        if (comp_r == '0) begin
          comp_nxt  = 2'd1;
          state_nxt = S_TINIT;
        end else begin
          sel_nxt   = MSEL_RS;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        ctl.op    = OP_MUL;
        state_nxt = S_MWB;
      end
      S_MWB: begin
        ctl.op = OP_MUL_WB;
        unique case (sel_r)
          MSEL_Z:   state_nxt = S_OUT;
          MSEL_SQZ: state_nxt = S_SQI;
          // squares walk the offset components along with the select
          MSEL_SQX, MSEL_SQY: begin
            sel_nxt   = sel_r + 1'b1;
            comp_nxt  = comp_r + 1'b1;
            state_nxt = S_MUL;
          end
          MSEL_NUM: begin
            cnt_nxt   = '0;
            state_nxt = S_DSTEP;
          end
          default: begin
            sel_nxt   = sel_r + 1'b1;
            state_nxt = S_MUL;
          end
        endcase
      end
      S_SQI: begin
        ctl.op    = OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        ctl.op  = OP_SQRT_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.len_zero) begin
          state_nxt = S_RAD;
        end else begin
          comp_nxt  = '0;
          sel_nxt   = MSEL_NUM;
          state_nxt = S_MUL;
        end
      end
      S_DSTEP: begin
        ctl.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_DWB;
      end
      S_DWB: begin
        ctl.op = OP_DIV_WB;
        if (comp_r == COMP_LAST) begin
          state_nxt = S_RAD;
        end else begin
          comp_nxt  = comp_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_RAD: begin
        ctl.op    = OP_RADIUS;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_fire) begin
          ctl.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/ocs_cordic.sv
module ocs_cordic
  import ocs_pkg::*;
(
  input  logic                     clk,
  input  logic                     init,
  input  logic                     step,
  input  logic [ITER_IW-1:0]       iter,
  input  logic signed [ANG_W-1:0]  angle,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  logic signed [TRIG_W-1:0] x_r, y_r, z_r;
  logic                     neg_r;
  logic signed [TRIG_W-1:0] z0, z1, z2, zr;
  logic                     zneg;
  logic signed [TRIG_W-1:0] xs, ys, at;

  // Range reduction into [-pi/2, pi/2]
  always_comb begin
    z0   = {{(TRIG_W-32){angle[ANG_W-1]}}, angle, 16'b0};
    z1   = (z0 > PI_Q28) ? z0 - TWO_PI_Q28 : z0;
    z2   = (z1 < -PI_Q28) ? z1 + TWO_PI_Q28 : z1;
    zneg = 1'b0;
    zr   = z2;
    if (z2 > HALF_PI_Q28) begin
      zr   = z2 - PI_Q28;
      zneg = 1'b1;
    end else if (z2 < -HALF_PI_Q28) begin
      zr   = z2 + PI_Q28;
      zneg = 1'b1;
    end
  end

  assign xs = x_r >>> iter;
  assign ys = y_r >>> iter;
  assign at = atan_q28(iter);

  // One rotation per cycle
  always_ff @(posedge clk) begin
    if (init) begin
      x_r   <= CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= zr;
      neg_r <= zneg;
    end else if (step) begin
      if (!z_r[TRIG_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign sin_o = neg_r ? -y_r : y_r;
  assign cos_o = neg_r ? -x_r : x_r;

endmodule

>>> design/ocs_dp.sv
module ocs_dp
  import ocs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  ctl_t                        ctl,
  output stat_t                       stat,
  input  logic [CMD_W-1:0]            in_command,
  input  logic signed [VAL_W-1:0]     in_value_x,
  input  logic signed [VAL_W-1:0]     in_value_y,
  input  logic signed [VAL_W-1:0]     in_value_z,
  input  logic                        cfg_we,
  input  logic [CFG_IW-1:0]           cfg_index,
  input  logic [CFG_DW-1:0]           cfg_wdata,
  output logic [OUT_TDATA_W-1:0]      out_data
);

  // Configuration
  logic [AS_W-1:0]   angle_step_r;
  logic [DS_W-1:0]   dist_step_r;
  logic [MINR_W-1:0] min_radius_r;

  // Camera state
  logic [EL_W-1:0]          el_r;
  logic signed [ANG_W-1:0]  az_r;
  logic signed [VAL_W-1:0]  rad_r, ox_r, oy_r, oz_r;
  command_t                 cmd_r;

  // Working registers
  logic signed [TRIG_W-1:0] se_r, ce_r, sa_r, ca_r;
  logic signed [VAL_W-1:0]  rs_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [SQ_W-1:0]          sq_r;
  logic [ROOT_W-1:0]        len_r;
  logic [SREM_W-1:0]        srem_r;
  logic [NUM_W-1:0]         num_r;
  logic [ROOT_W-1:0]        drem_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  command_t                 in_cmd;
  logic signed [16:0]       dang, az_sum, az_wrap, el_sum, el_clamp;
  logic signed [ANG_W-1:0]  trig_angle;
  logic signed [TRIG_W-1:0] cs_sin, cs_cos;
  logic signed [VAL_W-1:0]  osel;
  logic [MA_W-1:0]          omag;
  logic signed [MA_W-1:0]   ma;
  logic signed [TRIG_W-1:0] mb;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [28:0]       rnd;
  logic [SREM_W-1:0]        srem_sh, strial;
  logic [ROOT_W:0]          drem_sh;
  logic signed [25:0]       dmv, onew;
  logic signed [VAL_W:0]    rad_mv;

  assign in_cmd = command_t'(in_command);

  // Angle step for the four turn commands
  always_comb begin
    dang = {4'b0, angle_step_r};
    if (in_cmd == CMD_LEFT || in_cmd == CMD_UP) dang = -dang;
    az_sum = 17'(az_r) + dang;
    if (az_sum < 0)               az_wrap = az_sum + TWO_PI_Q12;
    else if (az_sum > TWO_PI_Q12) az_wrap = az_sum - TWO_PI_Q12;
    else                          az_wrap = az_sum;
    el_sum = $signed({3'b0, el_r}) + dang;
    if (el_sum < EL_MIN_Q12)      el_clamp = EL_MIN_Q12;
    else if (el_sum > EL_MAX_Q12) el_clamp = EL_MAX_Q12;
    else                          el_clamp = el_sum;
  end

  assign trig_angle = (ctl.comp == '0) ? $signed({2'b0, el_r}) : az_r;

  ocs_cordic u_cordic (
    .clk   (clk),
    .init  (ctl.op == OP_TRIG_INIT),
    .step  (ctl.op == OP_TRIG_STEP),
    .iter  (ctl.cnt[ITER_IW-1:0]),
    .angle (trig_angle),
    .sin_o (cs_sin),
    .cos_o (cs_cos)
  );

  // Offset component and its magnitude
  always_comb begin
    case (ctl.comp)
      2'd0:    osel = ox_r;
      2'd1:    osel = oy_r;
      default: osel = oz_r;
    endcase
    omag = osel[VAL_W-1] ? MA_W'(-25'(osel)) : MA_W'(25'(osel));
  end

  // Multiplier operands
  always_comb begin
    case (ctl.sel)
      MSEL_RS:  begin ma = 25'(rad_r); mb = se_r; end
      MSEL_X:   begin ma = 25'(rs_r);  mb = ca_r; end
      MSEL_Y:   begin ma = 25'(rad_r); mb = ce_r; end
      MSEL_Z:   begin ma = 25'(rs_r);  mb = sa_r; end
      MSEL_NUM: begin ma = $signed(omag); mb = $signed({18'b0, dist_step_r}); end
      default:  begin ma = 25'(osel);  mb = TRIG_W'(osel); end
    endcase
  end

  assign prod_rnd = prod_r + (PROD_W'(1) <<< 29);
  assign rnd      = prod_rnd[PROD_W-1:30];

  // Square root and divider steps
  assign srem_sh = {srem_r[SREM_W-3:0], sq_r[SQ_W-1 -: 2]};
  assign strial  = {1'b0, len_r, 2'b01};
  assign drem_sh = {drem_r, num_r[NUM_W-1]};

  // Move of one component by the rounded step
  always_comb begin
    dmv = osel[VAL_W-1] ? -26'($signed({1'b0, num_r[Q_W-1:0]}))
                        : 26'($signed({1'b0, num_r[Q_W-1:0]}));
    onew = (cmd_r == CMD_FWD) ? 26'(osel) - dmv : 26'(osel) + dmv;
    rad_mv = (cmd_r == CMD_FWD) ? 25'(rad_r) - $signed({9'b0, dist_step_r})
                                : 25'(rad_r) + $signed({9'b0, dist_step_r});
  end

  assign stat.le_min   = (rad_r <= $signed({1'b0, min_radius_r}));
  assign stat.len_zero = (len_r == '0);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_step_r <= ANGLE_STEP_RST;
      dist_step_r  <= DIST_STEP_RST;
      min_radius_r <= MIN_RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_STEP: angle_step_r <= cfg_wdata[AS_W-1:0];
        CFG_DIST_STEP:  dist_step_r  <= cfg_wdata[DS_W-1:0];
        CFG_MIN_RADIUS: min_radius_r <= cfg_wdata[MINR_W-1:0];
        default: ;
      endcase
    end
  end

  // Camera state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      el_r  <= EL_RST;
      az_r  <= AZ_RST;
      rad_r <= RADIUS_RST;
      ox_r  <= '0;
      oy_r  <= '0;
      oz_r  <= OFFZ_RST;
      cmd_r <= CMD_FWD;
    end else begin
      case (ctl.op)
        OP_LOAD: begin
          cmd_r <= in_cmd;
          case (in_cmd)
            CMD_LEFT, CMD_RIGHT: az_r <= az_wrap[ANG_W-1:0];
            CMD_UP, CMD_DOWN:    el_r <= el_clamp[EL_W-1:0];
            CMD_SET_RAD:         rad_r <= in_value_x;
            CMD_SET_OFF: begin
              ox_r <= in_value_x;
              oy_r <= in_value_y;
              oz_r <= in_value_z;
            end
            default: ;
          endcase
        end
        OP_MUL_WB: begin
          case (ctl.sel)
            MSEL_X: ox_r <= sat24(32'(rnd));
            MSEL_Y: oy_r <= sat24(32'(rnd));
            MSEL_Z: oz_r <= sat24(-32'(rnd));
            default: ;
          endcase
        end
        OP_DIV_WB: begin
          case (ctl.comp)
            2'd0:    ox_r <= sat24(32'(onew));
            2'd1:    oy_r <= sat24(32'(onew));
            default: oz_r <= sat24(32'(onew));
          endcase
        end
        OP_RADIUS: begin
          if (cmd_r == CMD_FWD && stat.le_min) rad_r <= $signed({1'b0, min_radius_r});
          else                                 rad_r <= sat24(32'(rad_mv));
        end
        default: ;
      endcase
    end
  end

  // Working registers of the shared units
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_TRIG_SAVE: begin
        if (ctl.comp == '0) begin
          se_r <= cs_sin;
          ce_r <= cs_cos;
        end else begin
          sa_r <= cs_sin;
          ca_r <= cs_cos;
        end
      end
      OP_MUL: prod_r <= ma * mb;
      OP_MUL_WB: begin
        case (ctl.sel)
          MSEL_RS:  rs_r <= sat24(32'(rnd));
          MSEL_SQX: sq_r <= prod_r[SQ_W-1:0];
          MSEL_SQY, MSEL_SQZ: sq_r <= sq_r + prod_r[SQ_W-1:0];
          MSEL_NUM: begin
            num_r  <= prod_r[NUM_W-1:0] + NUM_W'(len_r >> 1);
            drem_r <= '0;
          end
          default: ;
        endcase
      end
      OP_SQRT_INIT: begin
        srem_r <= '0;
        len_r  <= '0;
      end
      OP_SQRT_STEP: begin
        sq_r <= sq_r << 2;
        if (srem_sh >= strial) begin
          srem_r <= srem_sh - strial;
          len_r  <= {len_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_r <= srem_sh;
          len_r  <= {len_r[ROOT_W-2:0], 1'b0};
        end
      end
      OP_DIV_STEP: begin
        if (drem_sh >= {1'b0, len_r}) begin
          drem_r <= ROOT_W'(drem_sh - {1'b0, len_r});
          num_r  <= {num_r[NUM_W-2:0], 1'b1};
        end else begin
          drem_r <= drem_sh[ROOT_W-1:0];
          num_r  <= {num_r[NUM_W-2:0], 1'b0};
        end
      end
      OP_OUT: begin
        out_data_r <= {2'b0, az_r, el_r, rad_r, oz_r, oy_r, ox_r};
      end
      default: ;
    endcase
  end

  assign out_data = out_data_r;

endmodule

>>> design/orbit_camera_stepper.sv
// Sequence: set commands go straight to the result register; turn and tilt commands
//   run one shared CORDIC, then one shared multiplier;
//   forward/backward commands go through a bit-serial divider.
// Throughput: one command at a time; the next is taken once the result is registered.
// Reset (rst_n low, synchronous) restores the camera pose and configuration defaults.
module orbit_camera_stepper
  import ocs_pkg::*;
#(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // command[2:0], value_x[26:3], value_y[50:27], value_z[74:51], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // eye_x[23:0], eye_y[47:24], eye_z[71:48], radius_now[95:72],
  // elevation_now[109:96], azimuth_now[125:110], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IW-1:0]      cfg_index,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  ctl_t  ctl;
  stat_t stat;

  ocs_ctrl #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tdata[CMD_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  ocs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_command (in_tdata[CMD_W-1:0]),
    .in_value_x ($signed(in_tdata[26:3])),
    .in_value_y ($signed(in_tdata[50:27])),
    .in_value_z ($signed(in_tdata[74:51])),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_data   (out_tdata)
  );

endmodule
